[sv/bms_pkg.sv]
// Package: widths, status codes and cell control type for the batch median sorter.
package bms_pkg;

  localparam int MAX_COUNT = 64;
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int SAMPLE_W  = 32;
  localparam int KEY_W     = 32;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
    key_t key;
  } cell_ctl_t;

  function automatic key_t to_key(input logic signed [SAMPLE_W-1:0] s);
    to_key = {~s[SAMPLE_W-1], s[SAMPLE_W-2:0]};
  endfunction

endpackage

[sv/bms_if.sv]
// Interfaces: sample request channel and median result channel.
interface bms_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bms_pkg::SAMPLE_W-1:0]    sample;
  logic                                   last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface bms_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bms_pkg::SAMPLE_W-1:0]    median;
  logic        [bms_pkg::COUNT_W-1:0]     count;
  logic        [bms_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output median, output count, output status, input ready);
  modport sink   (input valid, input median, input count, input status, output ready);
endinterface

[sv/bms_cell.sv]
// One compare-and-shift cell of the sorted chain.
module bms_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  bms_pkg::cell_ctl_t  ctl,
  input  bms_pkg::key_t       left_key,
  input  logic                left_valid,
  input  logic                left_gt,
  input  bms_pkg::key_t       right_key,
  input  logic                right_valid,
  output bms_pkg::key_t       key,
  output logic                valid,
  output logic                gt
);
  import bms_pkg::*;

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;

  assign gt    = valid_r && (key_r > ctl.key);
  assign key   = key_r;
  assign valid = valid_r;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.pop) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end else if (ctl.ins) begin
      if (left_gt) begin
        key_nxt   = left_key;
        valid_nxt = 1'b1;
      end else if (left_valid && (gt || !valid_r)) begin
        key_nxt   = ctl.key;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

[sv/bms_chain.sv]
// Row of sorting cells; entry 0 holds the smallest key.
module bms_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  bms_pkg::cell_ctl_t  ctl,
  output bms_pkg::key_t       head_key
);
  import bms_pkg::*;

  key_t keys   [MAX_COUNT];
  logic valids [MAX_COUNT];
  logic gts    [MAX_COUNT];

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    key_t lk, rk;
    logic lv, lg, rv;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lv = 1'b1;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lk = keys[i-1];
      assign lv = valids[i-1];
      assign lg = gts[i-1];
    end
    if (i == MAX_COUNT - 1) begin : g_end
      assign rk = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rk = keys[i+1];
      assign rv = valids[i+1];
    end
    bms_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_key    (lk),
      .left_valid  (lv),
      .left_gt     (lg),
      .right_key   (rk),
      .right_valid (rv),
      .key         (keys[i]),
      .valid       (valids[i]),
      .gt          (gts[i])
    );
  end

  assign head_key = keys[0];

endmodule

[sv/batch_median_sorter.sv]
// Top level: batch median sorter with insertion chain and median readout.
// Samples up to MAX_COUNT are inserted in the cycle they are accepted, one per cycle.
// After the last sample the chain shifts out toward the head, one entry a cycle,
// up to the upper middle entry, then the averaged median is registered in S_DONE.
// No new request is taken during that readout; reset clears count, flags and chain.
module batch_median_sorter (
  input  logic       clk,
  input  logic       rst_n,
  bms_in_if.sink     in_ch,
  bms_out_if.source  out_ch
);
  import bms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DRAIN = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     kept_r, kept_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     pop_r, pop_nxt;
  key_t                 lo_r, lo_nxt, hi_r, hi_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] median_r, median_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;

  cell_ctl_t            ctl;
  key_t                 head_key;
  logic                 accept;
  logic [CNT_W-1:0]     lo_idx, hi_idx;
  logic [KEY_W:0]       pair_sum;
  key_t                 mid_key;

  bms_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .head_key (head_key)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign accept        = in_ch.valid && in_ch.ready;
  assign lo_idx        = (kept_r - CNT_W'(1)) >> 1;
  assign hi_idx        = kept_r >> 1;
  assign pair_sum      = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_key       = pair_sum[KEY_W:1];

  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = median_r;
  assign out_ch.count  = count_r;
  assign out_ch.status = status_r;

  always_comb begin
    state_nxt     = state_r;
    kept_nxt      = kept_r;
    ovf_nxt       = ovf_r;
    pop_nxt       = pop_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r;
    median_nxt    = median_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    ctl.ins       = 1'b0;
    ctl.pop       = 1'b0;
    ctl.clr       = 1'b0;
    ctl.key       = to_key(in_ch.sample);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (kept_r < CNT_W'(MAX_COUNT)) begin
            ctl.ins  = 1'b1;
            kept_nxt = kept_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last) begin
            pop_nxt   = '0;
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (kept_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          if (pop_r == lo_idx) begin
            lo_nxt = head_key;
          end
          if (pop_r == hi_idx) begin
            hi_nxt    = head_key;
            state_nxt = S_DONE;
          end else begin
            ctl.pop = 1'b1;
            pop_nxt = pop_r + CNT_W'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          count_nxt     = COUNT_W'(kept_r);
          if (kept_r == '0) begin
            median_nxt = '0;
            status_nxt = STATUS_EMPTY;
          end else begin
            median_nxt = $signed({~mid_key[KEY_W-1], mid_key[KEY_W-2:0]});
            status_nxt = ovf_r ? STATUS_OVERFLOW : STATUS_OK;
          end
          ctl.clr   = 1'b1;
          kept_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pop_r    <= pop_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    median_r <= median_nxt;
    count_r  <= count_nxt;
    status_r <= status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kept_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_r      <= kept_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
